### rtl/fermap_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fermap_pkg: shared types and constants of the fork extent read mapper
// Field widths, register indexes, result kinds and the descriptor that the
// front pipeline hands to the command sequencer.
// ----------------------------------------------------------------------------
package fermap_pkg;

  // Extent and step counts. Steps are the three extents, the zero fill
  // and the done item, in that order.
  localparam int NUM_EXT   = 3;
  localparam int NUM_STEPS = NUM_EXT + 2;
  localparam int STEP_ZERO = NUM_EXT;
  localparam int STEP_DONE = NUM_EXT + 1;

  // Field widths.
  localparam int LEN_W    = 32;
  localparam int EXT_W    = 16;
  localparam int BS_W     = 32;
  localparam int BASE_W   = 25;
  localparam int PSIZE_W  = 48;
  localparam int PROD_W   = EXT_W + BS_W;  // blocks times block size
  localparam int CUR_W    = PROD_W + 2;    // sum of three extents, plus base
  localparam int ADDR_W   = 48;
  localparam int KIND_W   = 2;

  // Stream and configuration port widths.
  localparam int IN_DATA_W  = 3 * LEN_W + 2 * NUM_EXT * EXT_W;
  localparam int OUT_DATA_W = ADDR_W + 2 * LEN_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BLOCK_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BASE_OFFS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PART_SIZE  = 2'd2;

  // Reset value of the block size register.
  localparam logic [BS_W-1:0] BLOCK_SIZE_RST = 32'd512;

  // Result item kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_READ     = 2'd0,
    KIND_ZERO     = 2'd1,
    KIND_DONE_OK  = 2'd2,
    KIND_DONE_ERR = 2'd3
  } item_kind_t;

  // Configuration registers as seen by the datapath.
  typedef struct packed {
    logic [BS_W-1:0]    block_size;
    logic [BASE_W-1:0]  base_offset;
    logic [PSIZE_W-1:0] part_size;
  } fermap_cfg_t;

  // One fully classified request, ready to be turned into result items.
  typedef struct packed {
    logic [NUM_EXT-1:0]             rd_active;
    logic [NUM_EXT-1:0]             rd_err;
    logic [NUM_EXT-1:0][ADDR_W-1:0] rd_addr;
    logic [NUM_EXT-1:0][LEN_W-1:0]  rd_dest;
    logic [NUM_EXT-1:0][LEN_W-1:0]  rd_take;
    logic                           zero_need;
    logic [LEN_W-1:0]               zero_dest;
    logic [LEN_W-1:0]               zero_cnt;
    logic [LEN_W-1:0]               total_len;
  } fermap_desc_t;

endpackage
`default_nettype wire

### rtl/fermap_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fermap_front: request classification pipeline
// Four register stages turn one request into a descriptor: clamped length
// and extent products, extent prefix sums, per-extent overlap, and segment
// address and length. The partition bound check is made on the way into
// the queue.
// ----------------------------------------------------------------------------
module fermap_front
  import fermap_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire fermap_cfg_t          cfg,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [IN_DATA_W-1:0] in_data,
  output logic                      push_valid,
  input  wire logic                 push_ready,
  output fermap_desc_t              push_desc
);

  // Pipeline advance: the whole pipeline moves unless the last stage is held.
  logic en;
  logic v1_r, v2_r, v3_r, v4_r;

  assign en         = !v4_r || push_ready;
  assign in_ready   = en;
  assign push_valid = v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: unpack, clamp the length to end of fork, extent products.
  // --------------------------------------------------------------------------
  logic [LEN_W-1:0]               in_fsize, in_off, in_len, in_avail;
  logic [NUM_EXT-1:0][EXT_W-1:0]  in_start, in_count;
  logic                           in_past;
  logic [LEN_W-1:0]               s1_len_nxt;
  logic [NUM_EXT-1:0][PROD_W-1:0] s1_ebytes_nxt, s1_sbytes_nxt;

  logic [LEN_W-1:0]               s1_off_r, s1_len_r;
  logic [NUM_EXT-1:0][PROD_W-1:0] s1_ebytes_r, s1_sbytes_r;

  always_comb begin
    in_fsize = in_data[LEN_W-1:0];
    in_off   = in_data[LEN_W + 2*NUM_EXT*EXT_W +: LEN_W];
    in_len   = in_data[2*LEN_W + 2*NUM_EXT*EXT_W +: LEN_W];
    for (int e = 0; e < NUM_EXT; e++) begin
      in_start[e]      = in_data[LEN_W + 2*EXT_W*e +: EXT_W];
      in_count[e]      = in_data[LEN_W + 2*EXT_W*e + EXT_W +: EXT_W];
      s1_ebytes_nxt[e] = PROD_W'(in_count[e]) * PROD_W'(cfg.block_size);
      s1_sbytes_nxt[e] = PROD_W'(in_start[e]) * PROD_W'(cfg.block_size);
    end
    // A request at or past end of fork has nothing to read.
    in_past    = in_off >= in_fsize;
    in_avail   = in_fsize - in_off;
    s1_len_nxt = in_past ? '0 : ((in_len > in_avail) ? in_avail : in_len);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_off_r    <= in_off;
      s1_len_r    <= s1_len_nxt;
      s1_ebytes_r <= s1_ebytes_nxt;
      s1_sbytes_r <= s1_sbytes_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: logical start of each extent and absolute extent base.
  // --------------------------------------------------------------------------
  logic [NUM_EXT:0][CUR_W-1:0]    s2_cur_nxt, s2_cur_r;
  logic [NUM_EXT-1:0][CUR_W-1:0]  s2_abase_nxt, s2_abase_r;
  logic [LEN_W-1:0]               s2_off_r, s2_len_r;
  logic [NUM_EXT-1:0][PROD_W-1:0] s2_ebytes_r;

  always_comb begin
    s2_cur_nxt[0] = '0;
    for (int e = 1; e <= NUM_EXT; e++) begin
      s2_cur_nxt[e] = '0;
      for (int j = 0; j < e; j++) begin
        s2_cur_nxt[e] = s2_cur_nxt[e] + CUR_W'(s1_ebytes_r[j]);
      end
    end
    for (int e = 0; e < NUM_EXT; e++) begin
      s2_abase_nxt[e] = CUR_W'(cfg.base_offset) + CUR_W'(s1_sbytes_r[e]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_cur_r    <= s2_cur_nxt;
      s2_abase_r  <= s2_abase_nxt;
      s2_off_r    <= s1_off_r;
      s2_len_r    <= s1_len_r;
      s2_ebytes_r <= s1_ebytes_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: overlap of each extent with the request. Coverage is contiguous
  // from the request offset, so the bytes delivered before an extent follow
  // from its logical start alone.
  // --------------------------------------------------------------------------
  logic [CUR_W-1:0]               s3_offw;
  logic [NUM_EXT:0]               s3_ahead;
  logic [NUM_EXT:0][CUR_W-1:0]    s3_gap;
  logic [NUM_EXT:0][LEN_W-1:0]    s3_done;
  logic [NUM_EXT-1:0][LEN_W-1:0]  s3_rel_nxt;
  logic [NUM_EXT-1:0]             s3_active_nxt;

  logic [LEN_W-1:0]               s3_len_r, s3_total_r;
  logic [NUM_EXT-1:0][LEN_W-1:0]  s3_dest_r, s3_rel_r;
  logic [NUM_EXT-1:0]             s3_active_r;
  logic [NUM_EXT-1:0][PROD_W-1:0] s3_ebytes_r;
  logic [NUM_EXT-1:0][CUR_W-1:0]  s3_abase_r;

  always_comb begin
    s3_offw = CUR_W'(s2_off_r);
    for (int e = 0; e <= NUM_EXT; e++) begin
      s3_ahead[e] = s2_cur_r[e] > s3_offw;
      s3_gap[e]   = s2_cur_r[e] - s3_offw;
      if (!s3_ahead[e]) begin
        s3_done[e] = '0;
      end else if (s3_gap[e] < CUR_W'(s2_len_r)) begin
        s3_done[e] = s3_gap[e][LEN_W-1:0];
      end else begin
        s3_done[e] = s2_len_r;
      end
    end
    for (int e = 0; e < NUM_EXT; e++) begin
      s3_rel_nxt[e]    = s3_ahead[e] ? '0 : (s2_off_r - s2_cur_r[e][LEN_W-1:0]);
      s3_active_nxt[e] = (s2_ebytes_r[e] != '0)
                      && (s3_ahead[e] ? (s3_gap[e] < CUR_W'(s2_len_r))
                                      : (s2_len_r != '0))
                      && (s3_offw < s2_cur_r[e+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_len_r    <= s2_len_r;
      s3_total_r  <= s3_done[NUM_EXT];
      s3_dest_r   <= s3_done[NUM_EXT-1:0];
      s3_rel_r    <= s3_rel_nxt;
      s3_active_r <= s3_active_nxt;
      s3_ebytes_r <= s2_ebytes_r;
      s3_abase_r  <= s2_abase_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: segment length and address of each read, zero-fill length.
  // --------------------------------------------------------------------------
  logic [NUM_EXT-1:0][PROD_W-1:0] s4_left;
  logic [NUM_EXT-1:0][LEN_W-1:0]  s4_rem, s4_take_nxt;
  logic [NUM_EXT-1:0][CUR_W-1:0]  s4_addr_nxt;

  logic [LEN_W-1:0]               s4_len_r, s4_total_r, s4_zcnt_r;
  logic                           s4_zneed_r;
  logic [NUM_EXT-1:0][LEN_W-1:0]  s4_dest_r, s4_take_r;
  logic [NUM_EXT-1:0][CUR_W-1:0]  s4_addr_r;
  logic [NUM_EXT-1:0]             s4_active_r;

  always_comb begin
    for (int e = 0; e < NUM_EXT; e++) begin
      s4_left[e]     = s3_ebytes_r[e] - PROD_W'(s3_rel_r[e]);
      s4_rem[e]      = s3_len_r - s3_dest_r[e];
      s4_take_nxt[e] = (s4_left[e] > PROD_W'(s4_rem[e])) ? s4_rem[e]
                                                         : s4_left[e][LEN_W-1:0];
      s4_addr_nxt[e] = s3_abase_r[e] + CUR_W'(s3_rel_r[e]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_len_r    <= s3_len_r;
      s4_total_r  <= s3_total_r;
      s4_zcnt_r   <= s3_len_r - s3_total_r;
      s4_zneed_r  <= s3_total_r < s3_len_r;
      s4_dest_r   <= s3_dest_r;
      s4_take_r   <= s4_take_nxt;
      s4_addr_r   <= s4_addr_nxt;
      s4_active_r <= s3_active_r;
    end
  end

  // Partition bound check and descriptor assembly.
  always_comb begin
    for (int e = 0; e < NUM_EXT; e++) begin
      push_desc.rd_err[e]  = ((CUR_W+1)'(s4_addr_r[e]) + (CUR_W+1)'(s4_take_r[e]))
                           > (CUR_W+1)'(cfg.part_size);
      push_desc.rd_addr[e] = s4_addr_r[e][ADDR_W-1:0];
    end
    push_desc.rd_active = s4_active_r;
    push_desc.rd_dest   = s4_dest_r;
    push_desc.rd_take   = s4_take_r;
    push_desc.zero_need = s4_zneed_r;
    push_desc.zero_dest = s4_total_r;
    push_desc.zero_cnt  = s4_zcnt_r;
    push_desc.total_len = s4_len_r;
  end

endmodule
`default_nettype wire

### rtl/fermap_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fermap_queue: descriptor queue between front and back
// A small register queue that lets the classification pipeline run ahead
// of the command sequencer.
// ----------------------------------------------------------------------------
module fermap_queue
  import fermap_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire fermap_desc_t  push_desc,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output fermap_desc_t       pop_desc
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  fermap_desc_t     entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = count_r != CNT_FULL;
  assign pop_valid  = count_r != '0;
  assign pop_desc   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule
`default_nettype wire

### rtl/fermap_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fermap_back: command sequencer
// Walks the steps of the head descriptor (three reads, zero fill, done),
// picks the next pending step in each cycle in which a descriptor waits
// and the output register can take an item, and emits one result item into it.
// ----------------------------------------------------------------------------
module fermap_back
  import fermap_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  output logic               q_ready,
  input  wire fermap_desc_t  q_desc,
  output logic               out_valid,
  input  wire logic          out_ready,
  output item_kind_t         out_kind,
  output logic [ADDR_W-1:0]  out_addr,
  output logic [LEN_W-1:0]   out_dest,
  output logic [LEN_W-1:0]   out_count,
  output logic               out_last
);

  // Steps still to be looked at for the head descriptor.
  logic [NUM_STEPS-1:0] rem_r, rem_nxt;
  logic [NUM_STEPS-1:0] avail, eff, sel;
  logic                 fire, finish;
  logic                 out_valid_r, out_valid_nxt;

  item_kind_t          kind_r, kind_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [LEN_W-1:0]    dest_r, dest_nxt, count_r, count_nxt;
  logic                last_r, last_nxt;

  // Lowest pending step wins; the done step is always pending.
  always_comb begin
    avail = {1'b1, q_desc.zero_need, q_desc.rd_active};
    eff   = avail & rem_r;
    sel   = eff & (~eff + NUM_STEPS'(1));
    fire  = q_valid && (!out_valid_r || out_ready);
  end

  // Item for the selected step.
  always_comb begin
    kind_nxt  = KIND_DONE_OK;
    addr_nxt  = '0;
    dest_nxt  = '0;
    count_nxt = q_desc.total_len;
    last_nxt  = 1'b1;
    finish    = 1'b1;
    for (int e = 0; e < NUM_EXT; e++) begin
      if (sel[e]) begin
        if (q_desc.rd_err[e]) begin
          // Read past the partition end: stop with an error.
          kind_nxt  = KIND_DONE_ERR;
          count_nxt = '0;
        end else begin
          kind_nxt  = KIND_READ;
          addr_nxt  = q_desc.rd_addr[e];
          dest_nxt  = q_desc.rd_dest[e];
          count_nxt = q_desc.rd_take[e];
          last_nxt  = 1'b0;
          finish    = 1'b0;
        end
      end
    end
    if (sel[STEP_ZERO]) begin
      kind_nxt  = KIND_ZERO;
      dest_nxt  = q_desc.zero_dest;
      count_nxt = q_desc.zero_cnt;
      last_nxt  = 1'b0;
      finish    = 1'b0;
    end
  end

  // Step mask and output valid.
  always_comb begin
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (fire) begin
      out_valid_nxt = 1'b1;
      rem_nxt       = finish ? '1 : (rem_r & ~(sel | (sel - NUM_STEPS'(1))));
    end
  end

  assign q_ready = fire && finish;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= '1;
      out_valid_r <= 1'b0;
    end else begin
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      kind_r  <= kind_nxt;
      addr_r  <= addr_nxt;
      dest_r  <= dest_nxt;
      count_r <= count_nxt;
      last_r  <= last_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = kind_r;
  assign out_addr  = addr_r;
  assign out_dest  = dest_r;
  assign out_count = count_r;
  assign out_last  = last_r;

endmodule
`default_nettype wire

### rtl/fork_extent_read_mapper_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fork_extent_read_mapper_core: fork extent read mapper, top level
// Maps one fork read request onto disk read, zero-fill and done items.
// ----------------------------------------------------------------------------
// A request is taken on every cycle in which the descriptor queue has room
// or the last pipeline stage is empty: a four-stage classification pipeline
// computes every read segment at once and parks the result in a descriptor
// queue of QUEUE_DEPTH entries. The command sequencer then sends one result
// item per cycle while the output is not stalled, one to five per request
// (reads, an optional zero fill and the done item, which carries tlast).
// The sequencer and its output port set the sustained rate; each request
// passes the pipeline stages, a queue entry and the output register.
// Configuration writes take effect at once and are to be made only while
// no request is in flight.
// ----------------------------------------------------------------------------
module fork_extent_read_mapper_core
  import fermap_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Configuration write port.
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // Request stream.
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // fork_size, ext0_start, ext0_count, ext1_start, ext1_count,
  // ext2_start, ext2_count, req_offset, req_length
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // Result stream.
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // disk_address, dest_offset, byte_count
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // item_kind
  output logic [KIND_W-1:0]          out_tuser,
  // last
  output logic                       out_tlast
);

  // Configuration registers.
  fermap_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.block_size  <= BLOCK_SIZE_RST;
      cfg_r.base_offset <= '0;
      cfg_r.part_size   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_IDX_BLOCK_SIZE: cfg_r.block_size  <= cfg_wdata[BS_W-1:0];
        CFG_IDX_BASE_OFFS:  cfg_r.base_offset <= cfg_wdata[BASE_W-1:0];
        CFG_IDX_PART_SIZE:  cfg_r.part_size   <= cfg_wdata[PSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Front pipeline to queue to sequencer.
  logic          push_valid, push_ready, pop_valid, pop_ready;
  fermap_desc_t  push_desc, pop_desc;
  item_kind_t    res_kind;
  logic [ADDR_W-1:0] res_addr;
  logic [LEN_W-1:0]  res_dest, res_count;

  fermap_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_data    (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc)
  );

  fermap_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_desc   (pop_desc)
  );

  fermap_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (pop_valid),
    .q_ready   (pop_ready),
    .q_desc    (pop_desc),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (res_kind),
    .out_addr  (res_addr),
    .out_dest  (res_dest),
    .out_count (res_count),
    .out_last  (out_tlast)
  );

  // Result packing.
  assign out_tdata = {res_count, res_dest, res_addr};
  assign out_tuser = res_kind;

endmodule
`default_nettype wire

### rtl/fermap_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fermap_checker: port-level checks of the fork extent read mapper
// Watches the result stream for item consistency and output stability,
// and is bound to the top level.
// ----------------------------------------------------------------------------
module fermap_checker
  import fermap_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic [KIND_W-1:0]     out_tuser,
  input wire logic                  out_tlast
);

  // A stalled item holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result item changed while stalled");

  // Only done items close a request.
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == ((out_tuser == KIND_DONE_OK)
                                  || (out_tuser == KIND_DONE_ERR))))
    else $error("tlast does not match a done item");

  // Only disk reads carry an address.
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != KIND_READ) |-> (out_tdata[ADDR_W-1:0] == '0))
    else $error("address on an item that is not a disk read");

  // An error report delivers nothing.
  a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_DONE_ERR)
      |-> (out_tdata[OUT_DATA_W-1:ADDR_W] == '0))
    else $error("error item with nonzero offset or count");

  // Reset empties the output.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind fork_extent_read_mapper_core fermap_checker u_fermap_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire

### dv/tb_fork_extent_read_mapper_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fork_extent_read_mapper_core: self-checking bench of the fork extent
// read mapper
// Sends fork read requests through the request stream under several block
// size, base offset and partition size settings. A local mapping function
// predicts the read, zero-fill and done items of each accepted request, and
// every item on the result stream is compared field by field with the
// oldest prediction. Both streams idle and stall at random.
// ----------------------------------------------------------------------------
module tb_fork_extent_read_mapper_core;
  import fermap_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;
  localparam logic [PSIZE_W-1:0]   PART_SIZE_MAX  = 48'hFFFF_FFFF_FFFF;
  localparam logic [BS_W-1:0]      BLOCK_SIZE_MAX = 32'd4294966784;
  localparam logic [BASE_W-1:0]    BASE_OFFS_MAX  = 25'd33553920;
  localparam int                   SETTLE_CYCLES  = 20;

  // One fork read request as it travels on the request stream.
  typedef struct {
    logic [LEN_W-1:0] fork_size;
    logic [EXT_W-1:0] ext_start [NUM_EXT];
    logic [EXT_W-1:0] ext_count [NUM_EXT];
    logic [LEN_W-1:0] req_offset;
    logic [LEN_W-1:0] req_length;
  } fork_req_t;

  // One expected result item.
  typedef struct {
    item_kind_t        kind;
    logic [ADDR_W-1:0] disk_addr;
    logic [LEN_W-1:0]  dest_offs;
    logic [LEN_W-1:0]  byte_cnt;
    logic              last;
  } mapped_cmd_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [KIND_W-1:0]     out_tuser;
  logic                  out_tlast;

  // Local copy of the configuration registers.
  logic [BS_W-1:0]    blk_size = BLOCK_SIZE_RST;
  logic [BASE_W-1:0]  base_offs = '0;
  logic [PSIZE_W-1:0] part_size = '0;

  mapped_cmd_t mapped_cmds[$];
  mapped_cmd_t head_cmd;
  int          fail_count = 0;
  bit          steady_mode = 1'b0;
  int          ready_hold = 0;
  int unsigned ready_pick;

  fork_extent_read_mapper_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #6 clk = ~clk;

  // Run limit, far above the slowest correct run.
  initial begin
    #12_000_000;
    $display("fork_extent_read_mapper_core test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void push_cmd(item_kind_t kind, logic [63:0] addr,
                                   logic [63:0] dest, logic [63:0] cnt, logic last);
    mapped_cmd_t c;
    c.kind      = kind;
    c.disk_addr = addr[ADDR_W-1:0];
    c.dest_offs = dest[LEN_W-1:0];
    c.byte_cnt  = cnt[LEN_W-1:0];
    c.last      = last;
    mapped_cmds.push_back(c);
  endfunction

  // Walks the three extents of a request and queues the items it must cause.
  function automatic void map_fork_read(fork_req_t r);
    logic [63:0] fsize, offs, len, done, cursor;
    logic [63:0] span_bytes, ext_end, pos, rel, take, addr;
    fsize  = 64'(r.fork_size);
    offs   = 64'(r.req_offset);
    len    = 64'(r.req_length);
    done   = '0;
    cursor = '0;
    // A request at or past the end of the fork delivers nothing.
    if (offs >= fsize) begin
      push_cmd(KIND_DONE_OK, 0, 0, 0, 1'b1);
      return;
    end
    if (len > fsize - offs) len = fsize - offs;
    for (int e = 0; e < NUM_EXT; e++) begin
      if (done >= len) break;
      span_bytes = 64'(r.ext_count[e]) * 64'(blk_size);
      if (span_bytes == 0) continue;
      ext_end = cursor + span_bytes;
      pos     = offs + done;
      if (pos >= ext_end) begin
        cursor = ext_end;
        continue;
      end
      rel  = (pos > cursor) ? pos - cursor : 64'd0;
      take = span_bytes - rel;
      if (take > len - done) take = len - done;
      addr = 64'(base_offs) + 64'(r.ext_start[e]) * 64'(blk_size) + rel;
      // A read past the partition end stops the walk with an error.
      if (addr + take > 64'(part_size)) begin
        push_cmd(KIND_DONE_ERR, 0, 0, 0, 1'b1);
        return;
      end
      push_cmd(KIND_READ, addr, done, take, 1'b0);
      done   = done + take;
      cursor = ext_end;
    end
    if (done < len) push_cmd(KIND_ZERO, 0, done, len - done, 1'b0);
    push_cmd(KIND_DONE_OK, 0, 0, len, 1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Every accepted result item is matched against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (mapped_cmds.size() == 0) begin
        $error("result item with nothing pending: kind %0d, data 0x%0h",
               out_tuser, out_tdata);
        fail_count++;
      end else begin
        head_cmd = mapped_cmds.pop_front();
        check_field("item_kind", 64'(head_cmd.kind), 64'(out_tuser));
        check_field("disk_address", 64'(head_cmd.disk_addr), 64'(out_tdata[47:0]));
        check_field("dest_offset", 64'(head_cmd.dest_offs), 64'(out_tdata[79:48]));
        check_field("byte_count", 64'(head_cmd.byte_cnt), 64'(out_tdata[111:80]));
        check_field("last", 64'(head_cmd.last), 64'(out_tlast));
      end
    end
  end

  // Result back pressure: mostly ready, short stalls, now and then a long one.
  always @(posedge clk) begin
    if (steady_mode) begin
      out_tready <= 1'b1;
      ready_hold = 0;
    end else if (ready_hold > 0) begin
      ready_hold--;
    end else begin
      ready_pick = $urandom_range(0, 99);
      if (ready_pick < 55) begin
        out_tready <= 1'b1;
        ready_hold = $urandom_range(0, 11);
      end else if (ready_pick < 92) begin
        out_tready <= 1'b0;
        ready_hold = $urandom_range(0, 2);
      end else begin
        out_tready <= 1'b0;
        ready_hold = $urandom_range(9, 39);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request and configuration drivers
  // ---------------------------------------------------------------------------

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (steady_mode || p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Sends one request, waits for it to be taken and records its items.
  task automatic send_request(fork_req_t r);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {r.req_length, r.req_offset,
                  r.ext_count[2], r.ext_start[2], r.ext_count[1], r.ext_start[1],
                  r.ext_count[0], r.ext_start[0], r.fork_size};
    do @(posedge clk); while (!in_tready);
    map_fork_read(r);
  endtask

  // Holds off new requests until every predicted item has come back.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (mapped_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_IDX_BLOCK_SIZE: blk_size  = data[BS_W-1:0];
      CFG_IDX_BASE_OFFS:  base_offs = data[BASE_W-1:0];
      CFG_IDX_PART_SIZE:  part_size = data[PSIZE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [BS_W-1:0] bs, logic [BASE_W-1:0] base,
                            logic [PSIZE_W-1:0] psize);
    wait_idle();
    write_reg(CFG_IDX_BLOCK_SIZE, 48'(bs));
    write_reg(CFG_IDX_BASE_OFFS, 48'(base));
    write_reg(CFG_IDX_PART_SIZE, psize);
    cfg_we <= 1'b0;
  endtask

  function automatic fork_req_t make_req(logic [31:0] fsize,
                                         logic [15:0] s0, logic [15:0] c0,
                                         logic [15:0] s1, logic [15:0] c1,
                                         logic [15:0] s2, logic [15:0] c2,
                                         logic [31:0] offs, logic [31:0] len);
    fork_req_t r;
    r.fork_size    = fsize;
    r.ext_start[0] = s0;
    r.ext_count[0] = c0;
    r.ext_start[1] = s1;
    r.ext_count[1] = c1;
    r.ext_start[2] = s2;
    r.ext_count[2] = c2;
    r.req_offset   = offs;
    r.req_length   = len;
    return r;
  endfunction

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Random request, mostly shaped like a real fork so that the walk gets deep:
  // fork size near the extent total, offsets near extent edges, lengths that
  // clamp. The rest is plain noise over every bit.
  function automatic fork_req_t gen_request();
    fork_req_t   r;
    logic [63:0] total, edge0;
    logic [31:0] sat;
    logic [32:0] bumped;
    if ($urandom_range(0, 99) < 15) begin
      r.fork_size = $urandom;
      for (int e = 0; e < NUM_EXT; e++) begin
        r.ext_start[e] = 16'($urandom);
        r.ext_count[e] = 16'($urandom);
      end
      r.req_offset = $urandom;
      r.req_length = $urandom;
      return r;
    end
    total = '0;
    for (int e = 0; e < NUM_EXT; e++) begin
      r.ext_start[e] = 16'($urandom);
      case ($urandom_range(0, 9))
        0, 1:    r.ext_count[e] = '0;
        2:       r.ext_count[e] = 16'($urandom);
        default: r.ext_count[e] = 16'($urandom_range(1, 8));
      endcase
      total = total + 64'(r.ext_count[e]) * 64'(blk_size);
    end
    sat = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
    case ($urandom_range(0, 3))
      0: r.fork_size = sat;
      1: begin
        bumped = 33'(sat) + 33'($urandom_range(1, 5000));
        r.fork_size = bumped[32] ? 32'hFFFF_FFFF : bumped[31:0];
      end
      2: r.fork_size = $urandom_range(0, sat);
      default: r.fork_size = $urandom;
    endcase
    edge0 = 64'(r.ext_count[0]) * 64'(blk_size);
    if (r.fork_size == 0) begin
      r.req_offset = $urandom_range(0, 3);
    end else begin
      case ($urandom_range(0, 9))
        0: r.req_offset = r.fork_size;
        1: r.req_offset = $urandom_range(r.fork_size, 32'hFFFF_FFFF);
        2: r.req_offset = '0;
        3: r.req_offset = edge0[31:0] - 32'($urandom_range(0, 3));
        default: r.req_offset = $urandom_range(0, r.fork_size - 1);
      endcase
    end
    case ($urandom_range(0, 9))
      0: r.req_length = '0;
      1: r.req_length = 32'hFFFF_FFFF;
      2: r.req_length = $urandom;
      default: begin
        if (r.fork_size > r.req_offset)
          r.req_length = $urandom_range(1, r.fork_size - r.req_offset);
        else
          r.req_length = $urandom_range(0, 100);
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: 512-byte blocks, base zero, empty partition, so any read
  // that carries bytes must fail.
  task automatic test_reset_defaults();
    send_request(make_req(32'd4096, 16'd0, 16'd8, 16'd0, 16'd0, 16'd0, 16'd0,
                          32'd0, 32'd4096));
    send_request(make_req(32'd4096, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                          32'd0, 32'd100));
    send_request(make_req(32'd0, 16'd3, 16'd3, 16'd3, 16'd3, 16'd3, 16'd3,
                          32'd0, 32'd10));
  endtask

  // Hand-picked requests: end of fork, zero length, clamping, spans over
  // extents, skipped extents, zero-fill tails and all-ones fields.
  task automatic test_directed_mapping();
    set_config(32'd512, 25'h1000, PART_SIZE_MAX);
    // Offset exactly at and far past the end of the fork.
    send_request(make_req(32'd1000, 16'd1, 16'd2, 16'd0, 16'd0, 16'd0, 16'd0,
                          32'd1000, 32'd5));
    send_request(make_req(32'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF));
    // Zero length inside the fork.
    send_request(make_req(32'd1000, 16'd1, 16'd2, 16'd0, 16'd0, 16'd0, 16'd0,
                          32'd10, 32'd0));
    // One extent covers the whole request.
    send_request(make_req(32'd2048, 16'd10, 16'd4, 16'd0, 16'd0, 16'd0, 16'd0,
                          32'd0, 32'd2048));
    // Clamped request that spans all three extents.
    send_request(make_req(32'd3072, 16'd5, 16'd1, 16'd40, 16'd2, 16'd900, 16'd3,
                          32'd100, 32'd3000));
    // Unused middle extent and a zero-fill tail.
    send_request(make_req(32'd5000, 16'd7, 16'd1, 16'd9, 16'd0, 16'd20, 16'd1,
                          32'd0, 32'd5000));
    // Start inside the second extent.
    send_request(make_req(32'd4096, 16'd2, 16'd2, 16'd100, 16'd4, 16'd0, 16'd0,
                          32'd1500, 32'd1000));
    // Start beyond every extent but inside the fork: zero fill alone.
    send_request(make_req(32'd8192, 16'd2, 16'd1, 16'd3, 16'd1, 16'd4, 16'd1,
                          32'd2000, 32'd3000));
    // All fields but the offset at their maximum.
    send_request(make_req(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          16'hFFFF, 16'hFFFF, 32'd0, 32'hFFFF_FFFF));
  endtask

  // Reads that end on, or cross, the partition end.
  task automatic test_partition_bound();
    set_config(32'd512, 25'd4096, 48'd4096 + 48'd20 * 48'd512);
    // First read fits, the second crosses the end.
    send_request(make_req(32'd3072, 16'd0, 16'd4, 16'd30, 16'd2, 16'd0, 16'd0,
                          32'd0, 32'd3072));
    // Read ending exactly on the partition end.
    send_request(make_req(32'd2048, 16'd16, 16'd4, 16'd0, 16'd0, 16'd0, 16'd0,
                          32'd0, 32'd2048));
    // One block further fails at once.
    send_request(make_req(32'd2048, 16'd17, 16'd4, 16'd0, 16'd0, 16'd0, 16'd0,
                          32'd0, 32'd2048));
  endtask

  // Zero and odd block sizes, and a write to the unused register index.
  task automatic test_block_size_corners();
    set_config(32'd0, 25'd0, PART_SIZE_MAX);
    send_request(make_req(32'd6000, 16'd1, 16'd5, 16'd2, 16'd5, 16'd3, 16'd5,
                          32'd100, 32'd6000));
    set_config(32'd1000, 25'd7, PART_SIZE_MAX);
    send_request(make_req(32'd5000, 16'd3, 16'd2, 16'd11, 16'd1, 16'd50, 16'd3,
                          32'd999, 32'd4500));
    // The unused index must leave every register as it was.
    wait_idle();
    write_reg(CFG_IDX_UNUSED, rand48());
    cfg_we <= 1'b0;
    send_request(make_req(32'd5000, 16'd3, 16'd2, 16'd11, 16'd1, 16'd50, 16'd3,
                          32'd1, 32'd4998));
  endtask

  // One configuration setting followed by a burst of random requests. Halfway
  // through a long burst the sender waits for every result to drain.
  task automatic run_phase(logic [BS_W-1:0] bs, logic [BASE_W-1:0] base,
                           logic [PSIZE_W-1:0] psize, int n, bit steady);
    set_config(bs, base, psize);
    steady_mode = steady;
    for (int i = 0; i < n; i++) begin
      if (n >= 40 && i == n / 2) wait_idle();
      send_request(gen_request());
    end
    steady_mode = 1'b0;
  endtask

  task automatic test_random_phases();
    run_phase(32'd512, 25'd0, PART_SIZE_MAX, 60, 1'b0);
    run_phase(32'd4096, {16'($urandom), 9'h0}, PART_SIZE_MAX, 50, 1'b1);
    run_phase(32'd512, 25'($urandom), 48'hFF_FFFF, 50, 1'b0);
    run_phase(BLOCK_SIZE_MAX, BASE_OFFS_MAX, PART_SIZE_MAX, 40, 1'b0);
    run_phase({23'($urandom_range(1, 8388607)), 9'h0}, {16'($urandom), 9'h0},
              rand48(), 50, 1'b0);
    run_phase(32'd0, 25'($urandom), rand48(), 30, 1'b0);
    run_phase(32'($urandom_range(1, 5000)), 25'($urandom), PART_SIZE_MAX, 50, 1'b0);
    run_phase(32'hFFFF_FFFF, 25'h1FF_FFFF, rand48(), 40, 1'b0);
    run_phase(32'd512, 25'd0, 48'd0, 40, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_directed_mapping();
    test_partition_bound();
    test_block_size_corners();
    test_random_phases();
    wait_idle();
    if (fail_count == 0) begin
      $display("fork_extent_read_mapper_core test passed");
    end else begin
      $display("fork_extent_read_mapper_core test failed");
    end
    $finish;
  end

endmodule
